// ===== src/mrq_pkg.sv =====
// Package for the message retry queue: result kinds, operation codes,
// register indexes and controller/datapath command and status types.
// No dependencies.
package mrq_pkg;

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_ACK   = 3'd2;
  localparam logic [2:0] OP_CLR   = 3'd3;
  localparam logic [2:0] OP_SEND  = 3'd4;

  localparam logic [2:0] K_SENT    = 3'd0;
  localparam logic [2:0] K_EXPIRED = 3'd1;
  localparam logic [2:0] K_ENQ     = 3'd2;
  localparam logic [2:0] K_FULL    = 3'd3;
  localparam logic [2:0] K_ACKED   = 3'd4;
  localparam logic [2:0] K_DONE    = 3'd5;

  localparam logic [2:0] R_TRY_LIMIT  = 3'd0;
  localparam logic [2:0] R_FIRST_IV   = 3'd1;
  localparam logic [2:0] R_IV_STEP    = 3'd2;
  localparam logic [2:0] R_STEP_KNEE  = 3'd3;
  localparam logic [2:0] R_LATE_TRIES = 3'd4;
  localparam logic [2:0] R_LATE_STEP  = 3'd5;
  localparam logic [2:0] R_MAX_IV     = 3'd6;

  localparam logic [5:0] SEQ_DIGITS = 6'd62;

  typedef struct packed {
    logic load;     // capture input word
    logic scan;     // examine slot at scan index (op dependent)
    logic enq;      // perform enqueue
    logic rel;      // release-search step on the pending peer
    logic rel_done; // apply release result
    logic emit_done;// emit plain result
  } mrq_cmd_t;

  typedef struct packed {
    logic scan_end;  // scan index at last slot
    logic ack_hit;   // ack matched; scan stops
    logic rel_pend;  // a release search is pending
    logic rel_end;   // release search at last slot
  } mrq_sts_t;

endpackage

// ===== src/message_retry_queue.sv =====
// Top level of the message retry queue: controller plus slot-table datapath.
// Depends on mrq_pkg, mrq_ctrl, mrq_datapath.
//
//  channel | handshake              | payload
//  in_     | start & !busy          | operation..now
//  out_    | out_valid (one cycle)  | kind..last
//  cfg_    | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// Enqueue passes through load, enqueue and end states. Tick, ack, clear and
// send-now walk the slot table with a scan and a release-check state per slot;
// each expiry or ack adds a release search over every slot. The slot walk sets the rate.
// Reset is synchronous; the table comes up empty. The receiver cannot
// stall: each word shows for one cycle with out_valid.
module message_retry_queue #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_station,
  input  logic [15:0] in_source_id,
  input  logic        in_is_system,
  input  logic [15:0] in_payload_handle,
  input  logic [15:0] in_path_handle,
  input  logic [11:0] in_ack_seq,
  input  logic [31:0] in_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [15:0] out_peer,
  output logic [15:0] out_sender,
  output logic [15:0] out_message_ref,
  output logic [15:0] out_route_ref,
  output logic [11:0] out_sequence_res,
  output logic [9:0]  out_attempt,
  output logic        out_last
);
  import mrq_pkg::*;

  mrq_cmd_t cmd;
  mrq_sts_t sts;

  // config is always taken; writes only land while idle by contract
  assign cfg_ready = 1'b1;

  mrq_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_operation, .sts, .cmd, .busy
  );

  mrq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_operation, .in_station, .in_source_id, .in_is_system,
    .in_payload_handle, .in_path_handle, .in_ack_seq, .in_now,
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .out_valid, .out_kind, .out_slot, .out_peer, .out_sender,
    .out_message_ref, .out_route_ref, .out_sequence_res, .out_attempt, .out_last
  );

  // last word closes its command: no word follows right behind it
  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("word right after last word");

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid) else $error("word while idle");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_FULL |-> out_peer == '0 && out_last)
    else $error("queue-full word not plain");

endmodule

// ===== src/mrq_datapath.sv =====
// Datapath of the message retry queue: slot table, scan logic, backoff.
// Depends on mrq_pkg.
module mrq_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrq_pkg::mrq_cmd_t   cmd,
  output mrq_pkg::mrq_sts_t   sts,
  input  logic [2:0]          in_operation,
  input  logic [15:0]         in_station,
  input  logic [15:0]         in_source_id,
  input  logic                in_is_system,
  input  logic [15:0]         in_payload_handle,
  input  logic [15:0]         in_path_handle,
  input  logic [11:0]         in_ack_seq,
  input  logic [31:0]         in_now,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [9:0]          cfg_val,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [3:0]          out_slot,
  output logic [15:0]         out_peer,
  output logic [15:0]         out_sender,
  output logic [15:0]         out_message_ref,
  output logic [15:0]         out_route_ref,
  output logic [11:0]         out_sequence_res,
  output logic [9:0]          out_attempt,
  output logic                out_last
);
  import mrq_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [9:0] try_limit_r, first_iv_r, knee_r, late_tries_r, max_iv_r;
  logic [7:0] step_r, late_step_r;

  logic [SLOTS-1:0] act_r, wait_r;
  logic [15:0] peer_r [SLOTS];
  logic [15:0] snd_r  [SLOTS];
  logic [15:0] pay_r  [SLOTS];
  logic [15:0] pth_r  [SLOTS];
  logic [11:0] seq_r  [SLOTS];
  logic [31:0] due_r  [SLOTS];
  logic [9:0]  iv_r   [SLOTS];
  logic [9:0]  tries_r[SLOTS];

  // sequence counter held as its two base-62 digits
  logic [5:0]  seq_hi_r, seq_lo_r;
  logic [31:0] last_tick_r;

  // captured word
  logic [2:0]  op_r;
  logic [15:0] st_r, src_r, pay_in_r, pth_in_r;
  logic        sys_r, tick_live_r;
  logic [11:0] ack_r;
  logic [31:0] now_r;

  logic [SW-1:0] idx_r;
  logic          hit_r;
  // release search
  logic          rel_pend_r;
  logic [15:0]   rel_peer_r;
  logic [SW-1:0] ridx_r, rbest_r;
  logic          rfound_r;

  logic [SW-1:0] free_idx;
  logic          free_any, wait_any;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    wait_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
      if (act_r[i] && peer_r[i] == st_r) wait_any = 1'b1;
    end
  end

  // next sequence number, base-62 two digits
  logic [5:0]  lo_d, hi_d;
  logic [11:0] seq_next;
  always_comb begin
    hi_d = seq_hi_r;
    lo_d = seq_lo_r;
    if (lo_d == SEQ_DIGITS - 6'd1) begin
      lo_d = '0;
      hi_d = (hi_d >= SEQ_DIGITS - 6'd1) ? 6'd1 : hi_d + 6'd1;
    end else begin
      lo_d = lo_d + 6'd1;
    end
    seq_next = 12'(hi_d) * 12'(SEQ_DIGITS) + 12'(lo_d);
  end

  // slot under scan
  logic        cur_hit_ack, cur_due, cur_peer;
  logic [9:0]  t_cur;
  logic [11:0] iv_w;
  logic [9:0]  iv_new;
  always_comb begin
    cur_peer    = act_r[idx_r] && peer_r[idx_r] == st_r;
    cur_hit_ack = cur_peer && snd_r[idx_r] == src_r && seq_r[idx_r] == ack_r;
    cur_due     = act_r[idx_r] && !wait_r[idx_r] && due_r[idx_r] < now_r;
    t_cur       = tries_r[idx_r];
    iv_w        = 12'(iv_r[idx_r]);
    if (iv_r[idx_r] < knee_r) iv_w = iv_w + 12'(step_r);
    if (t_cur >= late_tries_r) iv_w = iv_w + 12'(late_step_r);
    iv_new = (iv_w > 12'(max_iv_r)) ? max_iv_r : iv_w[9:0];
  end

  logic rel_better;
  assign rel_better = act_r[ridx_r] && peer_r[ridx_r] == rel_peer_r &&
                      (!rfound_r || seq_r[ridx_r] < seq_r[rbest_r]);

  // a word goes out on enqueue, on each tick send or expiry, on an ack hit and at done
  logic emit_w;
  assign emit_w = cmd.enq || cmd.emit_done ||
                  (cmd.scan && op_r == OP_TICK && tick_live_r && cur_due) ||
                  (cmd.scan && op_r == OP_ACK && cur_hit_ack);

  assign sts.scan_end = idx_r == SW'(SLOTS - 1);
  assign sts.ack_hit  = hit_r;
  assign sts.rel_pend = rel_pend_r;
  assign sts.rel_end  = ridx_r == SW'(SLOTS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      try_limit_r <= 10'd40;  first_iv_r <= 10'd7; step_r <= 8'd5;
      knee_r <= 10'd90; late_tries_r <= 10'd30; late_step_r <= 8'd30;
      max_iv_r <= 10'd600;
      act_r <= '0; wait_r <= '0;
      seq_hi_r <= '0; seq_lo_r <= '0; last_tick_r <= '0;
      rel_pend_r <= 1'b0; hit_r <= 1'b0; idx_r <= '0;
      tick_live_r <= 1'b0;
    end else begin
      out_valid <= emit_w;
      if (cfg_we) begin
        unique case (cfg_idx)
          R_TRY_LIMIT:  try_limit_r  <= cfg_val;
          R_FIRST_IV:   first_iv_r   <= cfg_val;
          R_IV_STEP:    step_r       <= cfg_val[7:0];
          R_STEP_KNEE:  knee_r       <= cfg_val;
          R_LATE_TRIES: late_tries_r <= cfg_val;
          R_LATE_STEP:  late_step_r  <= cfg_val[7:0];
          R_MAX_IV:     max_iv_r     <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.load) begin
        op_r <= in_operation; st_r <= in_station; src_r <= in_source_id;
        sys_r <= in_is_system; pay_in_r <= in_payload_handle;
        pth_in_r <= in_path_handle; ack_r <= in_ack_seq; now_r <= in_now;
        idx_r <= '0; hit_r <= 1'b0;
        tick_live_r <= in_now != last_tick_r;
        if (in_operation == OP_TICK) last_tick_r <= in_now;
      end
      if (cmd.enq) begin
        out_last <= 1'b1; out_attempt <= '0;
        if (!free_any) begin
          out_kind <= K_FULL; out_slot <= '0; out_peer <= '0; out_sender <= '0;
          out_message_ref <= '0; out_route_ref <= '0; out_sequence_res <= '0;
        end else begin
          act_r[free_idx]  <= 1'b1;
          wait_r[free_idx] <= wait_any && !sys_r;
          peer_r[free_idx] <= st_r; snd_r[free_idx] <= src_r;
          pay_r[free_idx] <= pay_in_r; pth_r[free_idx] <= pth_in_r;
          seq_r[free_idx] <= seq_next; seq_hi_r <= hi_d; seq_lo_r <= lo_d;
          due_r[free_idx] <= '0; iv_r[free_idx] <= first_iv_r;
          tries_r[free_idx] <= sys_r ? ((try_limit_r != 0) ? try_limit_r - 10'd1 : '0)
                                     : '0;
          out_kind <= K_ENQ; out_slot <= 4'(free_idx); out_peer <= st_r;
          out_sender <= src_r; out_message_ref <= pay_in_r;
          out_route_ref <= pth_in_r; out_sequence_res <= seq_next;
        end
      end
      if (cmd.scan) begin
        idx_r <= idx_r + SW'(1);
        unique case (op_r)
          OP_TICK: if (tick_live_r && cur_due) begin
            due_r[idx_r] <= now_r + 32'(iv_r[idx_r]);
            iv_r[idx_r] <= iv_new;
            tries_r[idx_r] <= (t_cur == 10'h3FF) ? t_cur : t_cur + 10'd1;
            out_last <= 1'b0;
            out_kind <= (t_cur >= try_limit_r) ? K_EXPIRED : K_SENT;
            out_slot <= 4'(idx_r); out_peer <= peer_r[idx_r];
            out_sender <= snd_r[idx_r]; out_message_ref <= pay_r[idx_r];
            out_route_ref <= pth_r[idx_r]; out_sequence_res <= seq_r[idx_r];
            out_attempt <= t_cur;
            if (t_cur >= try_limit_r) begin
              act_r[idx_r] <= 1'b0; wait_r[idx_r] <= 1'b0;
              rel_pend_r <= 1'b1; rel_peer_r <= peer_r[idx_r];
              ridx_r <= '0; rfound_r <= 1'b0;
            end
          end
          OP_ACK: if (cur_hit_ack) begin
            hit_r <= 1'b1;
            act_r[idx_r] <= 1'b0; wait_r[idx_r] <= 1'b0;
            rel_pend_r <= 1'b1; rel_peer_r <= st_r; ridx_r <= '0; rfound_r <= 1'b0;
            out_last <= 1'b1; out_kind <= K_ACKED;
            out_slot <= 4'(idx_r); out_peer <= peer_r[idx_r];
            out_sender <= snd_r[idx_r]; out_message_ref <= pay_r[idx_r];
            out_route_ref <= pth_r[idx_r]; out_sequence_res <= seq_r[idx_r];
            out_attempt <= '0;
          end
          OP_CLR: if (cur_peer) begin
            act_r[idx_r] <= 1'b0; wait_r[idx_r] <= 1'b0;
          end
          OP_SEND: if (cur_peer) due_r[idx_r] <= '0;
          default: ;
        endcase
      end
      if (cmd.rel) begin
        ridx_r <= ridx_r + SW'(1);
        if (rel_better) begin
          rbest_r <= ridx_r; rfound_r <= 1'b1;
        end
      end
      if (cmd.rel_done) begin
        rel_pend_r <= 1'b0;
        if (rfound_r) wait_r[rbest_r] <= 1'b0;
      end
      if (cmd.emit_done) begin
        out_last <= 1'b1; out_kind <= K_DONE;
        out_slot <= '0; out_peer <= '0; out_sender <= '0; out_message_ref <= '0;
        out_route_ref <= '0; out_sequence_res <= '0; out_attempt <= '0;
      end
    end
  end

endmodule

// ===== src/mrq_ctrl.sv =====
// Controller of the message retry queue: sequences load, scan, release, emit.
// Depends on mrq_pkg.
module mrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_operation,
  input  mrq_pkg::mrq_sts_t sts,
  output mrq_pkg::mrq_cmd_t cmd,
  output logic              busy
);
  import mrq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_RELD = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r;
  logic       last_scan_r, last_scan_nxt;

  assign busy = state_r != S_IDLE;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    last_scan_nxt = last_scan_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_nxt = (in_operation == OP_ENQ) ? S_ENQ : S_SCAN;
      end
      S_ENQ: begin
        cmd.enq = 1'b1;
        state_nxt = S_END;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        last_scan_nxt = sts.scan_end;
        // a hit or expiry raises rel_pend next cycle
        state_nxt = S_REL;
      end
      S_REL: begin
        if (sts.rel_pend) begin
          cmd.rel = 1'b1;
          if (sts.rel_end) state_nxt = S_RELD;
        end else if (sts.ack_hit && op_r == OP_ACK) begin
          state_nxt = S_END;
        end else if (last_scan_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_RELD: begin
        cmd.rel_done = 1'b1;
        state_nxt = S_REL;
      end
      S_DONE: begin
        cmd.emit_done = 1'b1;
        state_nxt = S_END;
      end
      S_END: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_scan_r <= 1'b0;
      op_r <= OP_ENQ;
    end else begin
      state_r <= state_nxt;
      last_scan_r <= last_scan_nxt;
      if (cmd.load) op_r <= in_operation;
    end
  end

endmodule

// ===== dv/tb_message_retry_queue.sv =====
// Testbench for message_retry_queue: drives enqueue/tick/ack/clear/send-now
// commands and register writes, predicts every result word and checks it.
// Depends on mrq_pkg and the message_retry_queue RTL.
`timescale 1ns / 100ps

module tb_message_retry_queue;
  import mrq_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] peer;
    logic [15:0] sender;
    logic [15:0] message_ref;
    logic [15:0] route_ref;
    logic [11:0] sequence_res;
    logic [9:0]  attempt;
    logic        last;
  } retry_word_t;

  class retry_queue_board;
    localparam int NSLOT = 16;
    logic [9:0]  try_limit, first_iv, iv_knee, late_tries, max_iv;
    logic [7:0]  iv_step, late_step;
    bit          act[NSLOT];
    bit          held[NSLOT];
    logic [15:0] peer[NSLOT], sender[NSLOT], msg[NSLOT], route[NSLOT];
    logic [11:0] seq[NSLOT];
    logic [31:0] due[NSLOT];
    logic [9:0]  ivl[NSLOT], tries[NSLOT];
    logic [11:0] seq_ctr;
    logic [31:0] last_tick;
    retry_word_t pending[$];
    int          errors;

    function void clear_state();
      try_limit = 40; first_iv = 7; iv_step = 5; iv_knee = 90;
      late_tries = 30; late_step = 30; max_iv = 600;
      foreach (act[i]) begin
        act[i] = 0; held[i] = 0; peer[i] = 0; sender[i] = 0; msg[i] = 0;
        route[i] = 0; seq[i] = 0; due[i] = 0; ivl[i] = 0; tries[i] = 0;
      end
      seq_ctr = 0; last_tick = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [9:0] d);
      case (idx)
        R_TRY_LIMIT:  try_limit = d;
        R_FIRST_IV:   first_iv = d;
        R_IV_STEP:    iv_step = d[7:0];
        R_STEP_KNEE:  iv_knee = d;
        R_LATE_TRIES: late_tries = d;
        R_LATE_STEP:  late_step = d[7:0];
        R_MAX_IV:     max_iv = d;
        default: ;
      endcase
    endfunction

    function void push_plain(logic [2:0] k);
      retry_word_t w;
      w = '0; w.kind = k; w.last = 1;
      pending.push_back(w);
    endfunction

    function void push_entry(logic [2:0] k, int s, logic [9:0] t, bit lst);
      retry_word_t w;
      w.kind = k; w.slot = s[3:0]; w.peer = peer[s]; w.sender = sender[s];
      w.message_ref = msg[s]; w.route_ref = route[s]; w.sequence_res = seq[s];
      w.attempt = t; w.last = lst;
      pending.push_back(w);
    endfunction

    // Unblock the lowest-sequence active entry to this peer.
    function void release_peer(logic [15:0] p);
      int b;
      b = -1;
      for (int i = 0; i < NSLOT; i++)
        if (act[i] && peer[i] == p && (b < 0 || seq[i] < seq[b])) b = i;
      if (b >= 0) held[b] = 0;
    endfunction

    function void note_command(logic [2:0] op, logic [15:0] st, logic [15:0] src,
                               logic sys, logic [15:0] pay, logic [15:0] pth,
                               logic [11:0] ack, logic [31:0] now);
      int fs, hi, lo;
      bit wt;
      logic [9:0] t;
      int iv;
      case (op)
        OP_ENQ: begin
          fs = -1; wt = 0;
          for (int i = 0; i < NSLOT; i++) begin
            if (act[i] && peer[i] == st && !sys) wt = 1;
            if (!act[i] && fs < 0) fs = i;
          end
          if (fs < 0) push_plain(K_FULL);
          else begin
            hi = (seq_ctr / 62) % 62; lo = seq_ctr % 62 + 1;
            if (lo == 62) begin
              lo = 0; hi++;
              if (hi == 62) hi = 1;
            end
            seq_ctr = 12'(hi * 62 + lo);
            act[fs] = 1; held[fs] = wt; peer[fs] = st; sender[fs] = src;
            msg[fs] = pay; route[fs] = pth; seq[fs] = seq_ctr; due[fs] = 0;
            ivl[fs] = first_iv;
            tries[fs] = sys ? (try_limit > 0 ? try_limit - 10'd1 : 10'd0) : 10'd0;
            push_entry(K_ENQ, fs, 0, 1);
          end
        end
        OP_TICK: begin
          if (now != last_tick) begin
            last_tick = now;
            for (int i = 0; i < NSLOT; i++) begin
              if (!act[i] || held[i] || !(due[i] < now)) continue;
              t = tries[i];
              due[i] = now + 32'(ivl[i]);
              iv = ivl[i];
              if (iv < iv_knee) iv += iv_step;
              if (t >= late_tries) iv += late_step;
              if (iv > max_iv) iv = max_iv;
              ivl[i] = iv[9:0];
              tries[i] = (t < 10'd1023) ? t + 10'd1 : 10'd1023;
              if (t >= try_limit) begin
                push_entry(K_EXPIRED, i, t, 0);
                act[i] = 0; held[i] = 0;
                release_peer(peer[i]);
              end else push_entry(K_SENT, i, t, 0);
            end
          end
          push_plain(K_DONE);
        end
        OP_ACK: begin
          for (int i = 0; i < NSLOT; i++)
            if (act[i] && peer[i] == st && sender[i] == src && seq[i] == ack) begin
              push_entry(K_ACKED, i, 0, 1);
              act[i] = 0; held[i] = 0;
              release_peer(st);
              return;
            end
          push_plain(K_DONE);
        end
        OP_CLR: begin
          for (int i = 0; i < NSLOT; i++)
            if (act[i] && peer[i] == st) begin
              act[i] = 0; held[i] = 0;
            end
          push_plain(K_DONE);
        end
        OP_SEND: begin
          for (int i = 0; i < NSLOT; i++) if (act[i] && peer[i] == st) due[i] = 0;
          push_plain(K_DONE);
        end
        default: push_plain(K_DONE);
      endcase
    endfunction

    function void check_word(retry_word_t got);
      retry_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word kind %0d", got.kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind) begin
        $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.slot != e.slot) begin
        $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.peer != e.peer) begin
        $error("peer exp %0h got %0h", e.peer, got.peer); errors++;
      end
      if (got.sender != e.sender) begin
        $error("sender exp %0h got %0h", e.sender, got.sender); errors++;
      end
      if (got.message_ref != e.message_ref) begin
        $error("message_ref exp %0h got %0h", e.message_ref, got.message_ref); errors++;
      end
      if (got.route_ref != e.route_ref) begin
        $error("route_ref exp %0h got %0h", e.route_ref, got.route_ref); errors++;
      end
      if (got.sequence_res != e.sequence_res) begin
        $error("sequence_res exp %0d got %0d", e.sequence_res, got.sequence_res); errors++;
      end
      if (got.attempt != e.attempt) begin
        $error("attempt exp %0d got %0d", e.attempt, got.attempt); errors++;
      end
      if (got.last != e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [15:0] in_station = '0, in_source_id = '0;
  logic        in_is_system = 0;
  logic [15:0] in_payload_handle = '0, in_path_handle = '0;
  logic [11:0] in_ack_seq = '0;
  logic [31:0] in_now = '0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [3:0]  out_slot;
  logic [15:0] out_peer, out_sender, out_message_ref, out_route_ref;
  logic [11:0] out_sequence_res;
  logic [9:0]  out_attempt;
  logic        out_last;
  retry_word_t got;

  retry_queue_board board;
  int  idle_pct;     // chance, in percent, that the sender holds off a cycle
  logic [31:0] clock_s;   // running time fed to tick commands
  logic [15:0] peers[4];  // small peer pool so entries collide and wait

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  message_retry_queue u_dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_station, .in_source_id, .in_is_system,
    .in_payload_handle, .in_path_handle, .in_ack_seq, .in_now,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_kind, .out_slot, .out_peer, .out_sender,
    .out_message_ref, .out_route_ref, .out_sequence_res, .out_attempt, .out_last
  );

  assign got = {out_kind, out_slot, out_peer, out_sender, out_message_ref,
                out_route_ref, out_sequence_res, out_attempt, out_last};

  // Check every result word at the edge that ends its cycle.
  always @(posedge clk)
    if (rst_n && out_valid) board.check_word(got);

  // Drain: wait for every expected word, then let the block settle.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_cfg(logic [2:0] idx, logic [9:0] d);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Present one command word and hold it until the block takes it.
  task automatic send_cmd(logic [2:0] op, logic [15:0] st, logic [15:0] src,
                          logic sys, logic [15:0] pay, logic [15:0] pth,
                          logic [11:0] ack, logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start <= 1; in_operation <= op; in_station <= st; in_source_id <= src;
    in_is_system <= sys; in_payload_handle <= pay; in_path_handle <= pth;
    in_ack_seq <= ack; in_now <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(op, st, src, sys, pay, pth, ack, now);
    @(negedge clk);
    start <= 0;
  endtask

  // Advance time and tick.
  task automatic tick(int step);
    clock_s = clock_s + step;
    send_cmd(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
             16'($urandom), 12'($urandom), clock_s);
  endtask

  // Random command, biased toward well-formed traffic on a small peer pool.
  task automatic random_cmd();
    int r, s;
    logic [15:0] p;
    r = $urandom_range(99);
    p = peers[$urandom_range(3)];
    s = $urandom_range(15);
    if (r < 35)
      send_cmd(OP_ENQ, p, 16'($urandom_range(3)), $urandom_range(9) == 0,
               16'($urandom), 16'($urandom), 12'($urandom), $urandom);
    else if (r < 65) tick($urandom_range(9) == 0 ? $urandom : $urandom_range(40));
    else if (r < 85) begin
      // Ack a live entry most of the time, a random sequence otherwise.
      if (board.act[s] && $urandom_range(4) != 0)
        send_cmd(OP_ACK, board.peer[s], board.sender[s], 1'($urandom),
                 16'($urandom), 16'($urandom), board.seq[s], $urandom);
      else
        send_cmd(OP_ACK, p, 16'($urandom_range(3)), 1'($urandom), 16'($urandom),
                 16'($urandom), 12'($urandom_range(4095)), $urandom);
    end
    else if (r < 91) send_cmd(OP_SEND, p, 16'($urandom), 1'($urandom), 16'($urandom),
                              16'($urandom), 12'($urandom), $urandom);
    else if (r < 95) send_cmd(OP_CLR, p, 16'($urandom), 1'($urandom), 16'($urandom),
                              16'($urandom), 12'($urandom), $urandom);
    else send_cmd(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                  1'($urandom), 16'($urandom), 16'($urandom), 12'($urandom),
                  $urandom);
  endtask

  initial begin
    #2000000;
    $display("tb_message_retry_queue: errors");
    $finish;
  end

  initial begin
    board = new();
    board.clear_state();
    idle_pct = 0;
    clock_s = 0;
    peers = '{16'h0001, 16'hffff, 16'h8000, 16'h5a5a};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: idle tick at zero, full table, waiting and release, expiry.
    send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_cmd(OP_ENQ, i < 3 ? 16'h0001 : 16'(i), 16'hffff, i == 5,
               16'(i * 4099), 16'hffff - 16'(i), 0, 0);
    send_cmd(OP_ACK, 16'h0001, 16'hffff, 0, 0, 0, 12'd2, 0);
    send_cmd(OP_ACK, 16'h0001, 16'hffff, 0, 0, 0, 12'd4095, 0);
    tick(5);
    tick(0);
    send_cmd(OP_SEND, 16'h0001, 0, 0, 0, 0, 0, 0);
    tick(1);
    send_cmd(OP_CLR, 16'h0001, 0, 0, 0, 0, 0, 0);
    send_cmd(3'd7, 16'hffff, 16'hffff, 1, 16'hffff, 16'hffff, 12'hfff, '1);
    send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 32'hffff_ffff);
    send_cmd(OP_CLR, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 4; i < 17; i++) send_cmd(OP_CLR, 16'(i), 0, 0, 0, 0, 0, 0);
    clock_s = 32'hffff_ff00;
    drain();

    // Quick expiry, tiny intervals, late backoff at once.
    write_cfg(R_TRY_LIMIT, 10'd1);
    write_cfg(R_FIRST_IV, 10'd1);
    write_cfg(R_IV_STEP, 10'd255);
    write_cfg(R_STEP_KNEE, 10'd1023);
    write_cfg(R_LATE_TRIES, 10'd0);
    write_cfg(R_LATE_STEP, 10'd255);
    write_cfg(R_MAX_IV, 10'd1023);
    for (int n = 0; n < 24; n++) random_cmd();
    drain();

    // Long lives: counters saturate on a slow entry pool; sender idles.
    write_cfg(R_TRY_LIMIT, 10'd1023);
    write_cfg(R_FIRST_IV, 10'd1023);
    write_cfg(R_IV_STEP, 10'd0);
    write_cfg(R_STEP_KNEE, 10'd1);
    write_cfg(R_LATE_TRIES, 10'd1023);
    write_cfg(R_LATE_STEP, 10'd0);
    write_cfg(R_MAX_IV, 10'd1);
    idle_pct = 74;
    for (int n = 0; n < 24; n++) random_cmd();
    drain();

    // Middle settings, including the system sender with a try limit of zero.
    write_cfg(R_TRY_LIMIT, 10'd0);
    write_cfg(R_FIRST_IV, 10'd3);
    write_cfg(R_IV_STEP, 10'd7);
    write_cfg(R_LATE_TRIES, 10'd2);
    write_cfg(R_LATE_STEP, 10'd11);
    write_cfg(R_MAX_IV, 10'd40);
    idle_pct = 22;
    for (int n = 0; n < 10; n++) random_cmd();
    drain();
    write_cfg(R_TRY_LIMIT, 10'd4);
    for (int n = 0; n < 31; n++) random_cmd();
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_message_retry_queue: clean");
    else
      $display("tb_message_retry_queue: errors");
    $finish;
  end
endmodule
